// ----- hdl/psds_pkg.sv -----
// package for the power setpoint dac search block
// types, widths and codes shared by the config, step and top modules; no dependencies
`timescale 1ns / 1ps

package psds_pkg;

  // default widths of the code and power registers
  localparam int CODE_WIDTH_DEF  = 16;
  localparam int POWER_WIDTH_DEF = 16;

  // fixed field and register widths
  localparam int KIND_W     = 2;
  localparam int FIELD_W    = 16;
  localparam int OUTCOME_W  = 2;
  localparam int HITS_W     = 16;
  localparam int ELAPSED_W  = 32;
  localparam int REQ_W      = 16;
  localparam int LIMIT_W    = 16;
  localparam int TIMEOUT_W  = 32;
  localparam int THR_W      = 16;
  localparam int STEP_W     = 16;
  localparam int WIN_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [REQ_W-1:0]     REQ_RST     = 16'd8;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 16'd4095;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 32'd5000;
  localparam logic [THR_W-1:0]     THR_RST     = 16'd10;
  localparam logic [STEP_W-1:0]    COARSE_RST  = 16'd16;
  localparam logic [STEP_W-1:0]    FINE_RST    = 16'd1;
  localparam logic [WIN_W-1:0]     WIN_RST     = 15'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_REGULATE = 2'd0,
    OUT_REACHED  = 2'd1,
    OUT_TIMEOUT  = 2'd2,
    OUT_FAIL     = 2'd3
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REQ_IN_WIN  = 3'd0,
    CFG_PROBE_LIMIT = 3'd1,
    CFG_TIMEOUT     = 3'd2,
    CFG_COARSE_THR  = 3'd3,
    CFG_COARSE_STEP = 3'd4,
    CFG_FINE_STEP   = 3'd5,
    CFG_WIN_HALF    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [REQ_W-1:0]     req_in_win;
    logic [LIMIT_W-1:0]   probe_limit;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [THR_W-1:0]     coarse_thr;
    logic [STEP_W-1:0]    coarse_step;
    logic [STEP_W-1:0]    fine_step;
    logic [WIN_W-1:0]     win_half;
  } cfg_t;

  // search control state
  typedef struct packed {
    logic                 running;
    logic                 first_sample;
    logic [HITS_W-1:0]    hits;
    logic [ELAPSED_W-1:0] elapsed;
  } cnt_t;

  // per-request result control
  typedef struct packed {
    logic     emit;
    outcome_e outcome;
  } res_t;

endpackage

// ----- hdl/psds_cfg.sv -----
// configuration register file of the power setpoint dac search block
// depends on psds_pkg
`timescale 1ns / 1ps

module psds_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [psds_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [psds_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output psds_pkg::cfg_t                   cfg_o
);

  psds_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (psds_pkg::cfg_idx_e'(cfg_index_i))
        psds_pkg::CFG_REQ_IN_WIN:  cfg_d.req_in_win    = cfg_wdata_i[psds_pkg::REQ_W-1:0];
        psds_pkg::CFG_PROBE_LIMIT: cfg_d.probe_limit   = cfg_wdata_i[psds_pkg::LIMIT_W-1:0];
        psds_pkg::CFG_TIMEOUT:     cfg_d.timeout_ticks = cfg_wdata_i[psds_pkg::TIMEOUT_W-1:0];
        psds_pkg::CFG_COARSE_THR:  cfg_d.coarse_thr    = cfg_wdata_i[psds_pkg::THR_W-1:0];
        psds_pkg::CFG_COARSE_STEP: cfg_d.coarse_step   = cfg_wdata_i[psds_pkg::STEP_W-1:0];
        psds_pkg::CFG_FINE_STEP:   cfg_d.fine_step     = cfg_wdata_i[psds_pkg::STEP_W-1:0];
        psds_pkg::CFG_WIN_HALF:    cfg_d.win_half      = cfg_wdata_i[psds_pkg::WIN_W-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.req_in_win    <= psds_pkg::REQ_RST;
      cfg_q.probe_limit   <= psds_pkg::LIMIT_RST;
      cfg_q.timeout_ticks <= psds_pkg::TIMEOUT_RST;
      cfg_q.coarse_thr    <= psds_pkg::THR_RST;
      cfg_q.coarse_step   <= psds_pkg::COARSE_RST;
      cfg_q.fine_step     <= psds_pkg::FINE_RST;
      cfg_q.win_half      <= psds_pkg::WIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/psds_step.sv -----
// next-state and result logic for one request of the dac search
// depends on psds_pkg
`timescale 1ns / 1ps

module psds_step #(
  parameter int CODE_WIDTH  = psds_pkg::CODE_WIDTH_DEF,
  parameter int POWER_WIDTH = psds_pkg::POWER_WIDTH_DEF
) (
  input  logic [psds_pkg::KIND_W-1:0]   kind_i,
  input  logic [psds_pkg::FIELD_W-1:0]  initial_code_i,
  input  logic [psds_pkg::FIELD_W-1:0]  target_power_i,
  input  logic [psds_pkg::FIELD_W-1:0]  measured_power_i,
  input  logic [CODE_WIDTH-1:0]         code_q_i,
  input  logic [POWER_WIDTH-1:0]        target_q_i,
  input  psds_pkg::cnt_t                cnt_q_i,
  input  psds_pkg::cfg_t                cfg_i,
  output logic [CODE_WIDTH-1:0]         code_d_o,
  output logic [POWER_WIDTH-1:0]        target_d_o,
  output psds_pkg::cnt_t                cnt_d_o,
  output psds_pkg::res_t                res_o
);

  // error width covers the power range and the window width plus sign
  localparam int EW  = ((POWER_WIDTH > psds_pkg::WIN_W) ? POWER_WIDTH : psds_pkg::WIN_W) + 2;
  localparam int CXW = (CODE_WIDTH > psds_pkg::FIELD_W) ? CODE_WIDTH : psds_pkg::FIELD_W;

  logic signed [POWER_WIDTH-1:0] p_s, t_s;
  logic signed [EW-1:0]          diff, mag;
  logic                          in_win, coarse, below, above;
  logic [psds_pkg::STEP_W-1:0]   inc;
  logic [CXW-1:0]                code_up, code_dn;
  logic [psds_pkg::HITS_W-1:0]   hits_new;
  logic                          reached, fail, timeout;

  assign p_s  = POWER_WIDTH'(measured_power_i);
  assign t_s  = target_q_i;
  assign diff = EW'(p_s) - EW'(t_s);
  assign mag  = diff[EW-1] ? -diff : diff;

  // window test is |p - target| <= w
  assign in_win = (mag <= $signed(EW'(cfg_i.win_half)));
  assign coarse = (mag >  $signed(EW'(cfg_i.coarse_thr)));
  assign below  = diff[EW-1];
  assign above  = !diff[EW-1] && (diff != '0);

  assign inc     = coarse ? cfg_i.coarse_step : cfg_i.fine_step;
  assign code_up = CXW'(code_q_i) + CXW'(inc);
  assign code_dn = CXW'(code_q_i) - CXW'(inc);

  always_comb begin
    hits_new = cnt_q_i.hits;
    if (!cnt_q_i.first_sample && in_win && (cnt_q_i.hits != '1)) begin
      hits_new = cnt_q_i.hits + 1'b1;
    end
  end

  assign reached = (hits_new >= cfg_i.req_in_win);
  assign fail    = (CXW'(code_q_i) >= CXW'(cfg_i.probe_limit));
  assign timeout = (cnt_q_i.elapsed > cfg_i.timeout_ticks);

  always_comb begin
    code_d_o    = code_q_i;
    target_d_o  = target_q_i;
    cnt_d_o     = cnt_q_i;
    res_o.emit    = 1'b0;
    res_o.outcome = psds_pkg::OUT_REGULATE;
    unique case (psds_pkg::kind_e'(kind_i))
      psds_pkg::KIND_START: begin
        code_d_o             = CODE_WIDTH'(initial_code_i);
        target_d_o           = POWER_WIDTH'(target_power_i);
        cnt_d_o.running      = 1'b1;
        cnt_d_o.first_sample = 1'b1;
        cnt_d_o.hits         = '0;
        cnt_d_o.elapsed      = '0;
        res_o.emit           = 1'b1;
      end
      psds_pkg::KIND_TICK: begin
        if (cnt_q_i.running && (cnt_q_i.elapsed != '1)) begin
          cnt_d_o.elapsed = cnt_q_i.elapsed + 1'b1;
        end
      end
      psds_pkg::KIND_SAMPLE: begin
        if (cnt_q_i.running) begin
          cnt_d_o.first_sample = 1'b0;
          cnt_d_o.hits         = hits_new;
          res_o.emit           = 1'b1;
          if (reached) begin
            cnt_d_o.running = 1'b0;
            res_o.outcome   = psds_pkg::OUT_REACHED;
          end else if (fail) begin
            cnt_d_o.running = 1'b0;
            res_o.outcome   = psds_pkg::OUT_FAIL;
          end else if (timeout) begin
            cnt_d_o.running = 1'b0;
            res_o.outcome   = psds_pkg::OUT_TIMEOUT;
          end else if (below) begin
            code_d_o = CODE_WIDTH'(code_up);
          end else if (above) begin
            code_d_o = CODE_WIDTH'(code_dn);
          end
        end
      end
      default: ; // unused kind, no result
    endcase
  end

endmodule

// ----- hdl/power_setpoint_dac_search.sv -----
// a request taken into the input register has its result written into the result register
// throughput: one request per cycle unless the result channel stalls; the search state is updated
// in one pass of psds_step between the input register and the result register
// reset: asynchronous active low; search idle, counters and code cleared, registers to defaults
// depends on psds_pkg, psds_cfg and psds_step
`timescale 1ns / 1ps

module power_setpoint_dac_search #(
  parameter int CODE_WIDTH  = psds_pkg::CODE_WIDTH_DEF,
  parameter int POWER_WIDTH = psds_pkg::POWER_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [psds_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [psds_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [psds_pkg::KIND_W-1:0]        kind_i,
  input  logic [psds_pkg::FIELD_W-1:0]       initial_code_i,
  input  logic signed [psds_pkg::FIELD_W-1:0] target_power_i,
  input  logic signed [psds_pkg::FIELD_W-1:0] measured_power_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [psds_pkg::FIELD_W-1:0]       dac_code_o,
  output logic [psds_pkg::OUTCOME_W-1:0]     outcome_o,
  output logic [psds_pkg::FIELD_W-1:0]       in_window_count_o,
  output logic [psds_pkg::FIELD_W-1:0]       elapsed_ms_o
);

  psds_pkg::cfg_t cfg;

  // input register
  logic                           in_vld_q;
  logic [psds_pkg::KIND_W-1:0]    kind_q;
  logic [psds_pkg::FIELD_W-1:0]   init_code_q, target_in_q, power_in_q;

  // search state
  logic [CODE_WIDTH-1:0]  code_q, code_d;
  logic [POWER_WIDTH-1:0] target_q, target_d;
  psds_pkg::cnt_t         cnt_q, cnt_d;
  psds_pkg::res_t         res;

  // result register
  logic                            out_vld_q;
  logic [psds_pkg::FIELD_W-1:0]    dac_q, hits_q, elapsed_q;
  logic [psds_pkg::OUTCOME_W-1:0]  outcome_q;

  logic out_free, s1_fire, in_fire;

  // result slot free when empty or being taken this cycle
  assign out_free   = !out_vld_q || out_ready_i;
  // the held request is processed once its result has somewhere to go
  assign s1_fire    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  psds_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  psds_step #(
    .CODE_WIDTH  (CODE_WIDTH),
    .POWER_WIDTH (POWER_WIDTH)
  ) u_step (
    .kind_i           (kind_q),
    .initial_code_i   (init_code_q),
    .target_power_i   (target_in_q),
    .measured_power_i (power_in_q),
    .code_q_i         (code_q),
    .target_q_i       (target_q),
    .cnt_q_i          (cnt_q),
    .cfg_i            (cfg),
    .code_d_o         (code_d),
    .target_d_o       (target_d),
    .cnt_d_o          (cnt_d),
    .res_o            (res)
  );

  // input register: valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // input register: payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q      <= kind_i;
      init_code_q <= initial_code_i;
      target_in_q <= target_power_i;
      power_in_q  <= measured_power_i;
    end
  end

  // search state, only moves when the held request is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q   <= '0;
      target_q <= '0;
      cnt_q    <= '0;
    end else if (s1_fire) begin
      code_q   <= code_d;
      target_q <= target_d;
      cnt_q    <= cnt_d;
    end
  end

  // result register: valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_fire && res.emit;
    end
  end

  // result register: payload taken from the updated state
  always_ff @(posedge clk_i) begin
    if (s1_fire && res.emit) begin
      dac_q     <= psds_pkg::FIELD_W'(code_d);
      outcome_q <= res.outcome;
      hits_q    <= cnt_d.hits;
      elapsed_q <= cnt_d.elapsed[psds_pkg::FIELD_W-1:0];
    end
  end

  assign out_valid_o       = out_vld_q;
  assign dac_code_o        = dac_q;
  assign outcome_o         = outcome_q;
  assign in_window_count_o = hits_q;
  assign elapsed_ms_o      = elapsed_q;

endmodule

// ----- tb/power_setpoint_dac_search_test.sv -----
// self-checking testbench for power_setpoint_dac_search: directed and random search sequences
// with random idling on both channels; a tracker class predicts each result and checks it
// depends on psds_pkg and power_setpoint_dac_search
`timescale 1ns / 1ps

module power_setpoint_dac_search_test;

  // kind and register slot that the block has no use for
  localparam logic [psds_pkg::KIND_W-1:0]    KIND_UNUSED  = 2'd3;
  localparam logic [psds_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 160;
  // margin after the last owed result has been taken
  localparam int SETTLE_CYCLES   = 4;

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  cfg_we_i;
  logic [psds_pkg::CFG_IDX_W-1:0]        cfg_index_i;
  logic [psds_pkg::CFG_DATA_W-1:0]       cfg_wdata_i;
  logic                                  in_valid_i;
  logic                                  in_ready_o;
  logic [psds_pkg::KIND_W-1:0]           kind_i;
  logic [psds_pkg::FIELD_W-1:0]          initial_code_i;
  logic signed [psds_pkg::FIELD_W-1:0]   target_power_i;
  logic signed [psds_pkg::FIELD_W-1:0]   measured_power_i;
  logic                                  out_valid_o;
  logic                                  out_ready_i;
  logic [psds_pkg::FIELD_W-1:0]          dac_code_o;
  logic [psds_pkg::OUTCOME_W-1:0]        outcome_o;
  logic [psds_pkg::FIELD_W-1:0]          in_window_count_o;
  logic [psds_pkg::FIELD_W-1:0]          elapsed_ms_o;

  // largest idle gap per request on each side; zero gives stretches at full rate
  int unsigned in_gap_max  = 19;
  int unsigned out_gap_max = 19;
  int          cycle_count = 0;

  typedef struct packed {
    logic [psds_pkg::FIELD_W-1:0] dac_code;
    psds_pkg::outcome_e           outcome;
    logic [psds_pkg::FIELD_W-1:0] window_count;
    logic [psds_pkg::FIELD_W-1:0] elapsed_ms;
  } dac_result_t;

  // tracks the search state and register settings, and holds the results still owed
  class setpoint_tracker;
    psds_pkg::cfg_t                      regs;
    logic [psds_pkg::FIELD_W-1:0]        code;
    logic signed [psds_pkg::FIELD_W-1:0] target;
    logic [psds_pkg::HITS_W-1:0]         hits;
    logic [psds_pkg::ELAPSED_W-1:0]      elapsed;
    bit                                  running;
    bit                                  first_sample;
    dac_result_t                         expected[$];
    int unsigned                         mismatches;

    function new();
      regs.req_in_win    = psds_pkg::REQ_RST;
      regs.probe_limit   = psds_pkg::LIMIT_RST;
      regs.timeout_ticks = psds_pkg::TIMEOUT_RST;
      regs.coarse_thr    = psds_pkg::THR_RST;
      regs.coarse_step   = psds_pkg::COARSE_RST;
      regs.fine_step     = psds_pkg::FINE_RST;
      regs.win_half      = psds_pkg::WIN_RST;
      code         = '0;
      target       = '0;
      hits         = '0;
      elapsed      = '0;
      running      = 1'b0;
      first_sample = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [psds_pkg::CFG_IDX_W-1:0] idx,
                            logic [psds_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        psds_pkg::CFG_REQ_IN_WIN:  regs.req_in_win    = data[psds_pkg::REQ_W-1:0];
        psds_pkg::CFG_PROBE_LIMIT: regs.probe_limit   = data[psds_pkg::LIMIT_W-1:0];
        psds_pkg::CFG_TIMEOUT:     regs.timeout_ticks = data[psds_pkg::TIMEOUT_W-1:0];
        psds_pkg::CFG_COARSE_THR:  regs.coarse_thr    = data[psds_pkg::THR_W-1:0];
        psds_pkg::CFG_COARSE_STEP: regs.coarse_step   = data[psds_pkg::STEP_W-1:0];
        psds_pkg::CFG_FINE_STEP:   regs.fine_step     = data[psds_pkg::STEP_W-1:0];
        psds_pkg::CFG_WIN_HALF:    regs.win_half      = data[psds_pkg::WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void owe(psds_pkg::outcome_e outc);
      dac_result_t r;
      r.dac_code     = code;
      r.outcome      = outc;
      r.window_count = hits;
      r.elapsed_ms   = elapsed[psds_pkg::FIELD_W-1:0];
      expected.push_back(r);
    endfunction

    // advances the search by one accepted request
    function void note_request(logic [psds_pkg::KIND_W-1:0] kind,
                               logic [psds_pkg::FIELD_W-1:0] init_code,
                               logic signed [psds_pkg::FIELD_W-1:0] tgt,
                               logic signed [psds_pkg::FIELD_W-1:0] meas);
      int                          p;
      int                          t;
      int                          w;
      int                          mag;
      logic [psds_pkg::STEP_W-1:0] step;
      case (kind)
        psds_pkg::KIND_START: begin
          code         = init_code;
          target       = tgt;
          hits         = '0;
          elapsed      = '0;
          running      = 1'b1;
          first_sample = 1'b1;
          owe(psds_pkg::OUT_REGULATE);
        end
        psds_pkg::KIND_TICK: begin
          if (running && elapsed != '1) elapsed = elapsed + 1'b1;
        end
        psds_pkg::KIND_SAMPLE: begin
          if (running) begin
            p   = meas;
            t   = target;
            w   = int'(regs.win_half);
            mag = (p > t) ? p - t : t - p;
            // first sample after a start is not counted as in window; it still steps the code
            if (first_sample) first_sample = 1'b0;
            else if (p <= t + w && p >= t - w && hits != '1) hits = hits + 1'b1;
            if (hits >= regs.req_in_win) begin
              running = 1'b0;
              owe(psds_pkg::OUT_REACHED);
            end else if (code >= regs.probe_limit) begin
              running = 1'b0;
              owe(psds_pkg::OUT_FAIL);
            end else if (elapsed > regs.timeout_ticks) begin
              running = 1'b0;
              owe(psds_pkg::OUT_TIMEOUT);
            end else begin
              step = (mag > int'(regs.coarse_thr)) ? regs.coarse_step : regs.fine_step;
              if (p < t) code = code + step;
              else if (p > t) code = code - step;
              owe(psds_pkg::OUT_REGULATE);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [psds_pkg::FIELD_W-1:0] dac,
                               logic [psds_pkg::OUTCOME_W-1:0] outc,
                               logic [psds_pkg::FIELD_W-1:0] cnt,
                               logic [psds_pkg::FIELD_W-1:0] ms);
      dac_result_t exp_r;
      if (expected.size() == 0) begin
        $error("result with nothing owed: dac_code %0d outcome %0d", dac, outc);
        mismatches++;
        return;
      end
      exp_r = expected.pop_front();
      if (dac !== exp_r.dac_code) begin
        $error("dac_code: expected %0d, actual %0d", exp_r.dac_code, dac);
        mismatches++;
      end
      if (outc !== exp_r.outcome) begin
        $error("outcome: expected %0d, actual %0d", exp_r.outcome, outc);
        mismatches++;
      end
      if (cnt !== exp_r.window_count) begin
        $error("in_window_count: expected %0d, actual %0d", exp_r.window_count, cnt);
        mismatches++;
      end
      if (ms !== exp_r.elapsed_ms) begin
        $error("elapsed_ms: expected %0d, actual %0d", exp_r.elapsed_ms, ms);
        mismatches++;
      end
    endfunction
  endclass

  setpoint_tracker sb = new();

  power_setpoint_dac_search dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .initial_code_i    (initial_code_i),
    .target_power_i    (target_power_i),
    .measured_power_i  (measured_power_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .dac_code_o        (dac_code_o),
    .outcome_o         (outcome_o),
    .in_window_count_o (in_window_count_o),
    .elapsed_ms_o      (elapsed_ms_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count > CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stall before taking each result
  initial begin : result_sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // every taken result goes to the checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(dac_code_o, outcome_o, in_window_count_o, elapsed_ms_o);
  end

  function automatic logic [psds_pkg::FIELD_W-1:0] any16();
    return psds_pkg::FIELD_W'($urandom());
  endfunction

  // one request: random gap, then hold valid until taken; called at a clock edge
  task automatic send_request(input logic [psds_pkg::KIND_W-1:0] kind,
                              input logic [psds_pkg::FIELD_W-1:0] code,
                              input logic signed [psds_pkg::FIELD_W-1:0] tgt,
                              input logic signed [psds_pkg::FIELD_W-1:0] meas);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    initial_code_i   <= code;
    target_power_i   <= tgt;
    measured_power_i <= meas;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(kind, code, tgt, meas);
  endtask

  // drop valid, wait for every owed result, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [psds_pkg::CFG_IDX_W-1:0] idx,
                         logic [psds_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // narrow registers get junk in the unused upper bits, which must be dropped
  task automatic write_settings(psds_pkg::cfg_t s);
    logic [psds_pkg::CFG_DATA_W-1:0] junk;
    junk = $urandom();
    put_reg(psds_pkg::CFG_REQ_IN_WIN,  {junk[31:16], s.req_in_win});
    put_reg(psds_pkg::CFG_PROBE_LIMIT, {junk[31:16], s.probe_limit});
    put_reg(psds_pkg::CFG_TIMEOUT,     s.timeout_ticks);
    put_reg(psds_pkg::CFG_COARSE_THR,  {junk[31:16], s.coarse_thr});
    put_reg(psds_pkg::CFG_COARSE_STEP, {junk[31:16], s.coarse_step});
    put_reg(psds_pkg::CFG_FINE_STEP,   {junk[31:16], s.fine_step});
    put_reg(psds_pkg::CFG_WIN_HALF,    {junk[31:15], s.win_half});
    // slot past the last register, must not disturb anything
    put_reg(CFG_IDX_NONE,              $urandom());
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int                                  done;
    int                                  roll;
    int                                  pick;
    int                                  span;
    int                                  off;
    psds_pkg::cfg_t                      reset_setting;
    psds_pkg::cfg_t                      setting;
    logic [psds_pkg::KIND_W-1:0]         kind;
    logic [psds_pkg::FIELD_W-1:0]        code;
    logic signed [psds_pkg::FIELD_W-1:0] tgt;
    logic signed [psds_pkg::FIELD_W-1:0] meas;

    reset_setting = sb.regs;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= '0;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    kind_i           <= psds_pkg::KIND_TICK;
    initial_code_i   <= '0;
    target_power_i   <= '0;
    measured_power_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings
    // search from code zero, samples at both power extremes
    send_request(psds_pkg::KIND_START,  16'd0, 16'sd0, any16());
    send_request(psds_pkg::KIND_SAMPLE, any16(), any16(), 16'sd0);
    send_request(psds_pkg::KIND_SAMPLE, any16(), any16(), 16'sh8000);
    send_request(psds_pkg::KIND_SAMPLE, any16(), any16(), 16'sh7FFF);
    // fine step down from zero wraps the code, then the next sample fails the search
    send_request(psds_pkg::KIND_SAMPLE, any16(), any16(), 16'sd3);
    send_request(psds_pkg::KIND_SAMPLE, any16(), any16(), 16'sd2);
    // idle: samples, ticks and the unused kind all ignored
    send_request(psds_pkg::KIND_SAMPLE, any16(), any16(), any16());
    send_request(psds_pkg::KIND_TICK,   any16(), any16(), any16());
    send_request(KIND_UNUSED,           any16(), any16(), any16());
    // code just under the probe limit, lowest target
    send_request(psds_pkg::KIND_START,  16'd4094, 16'sh8000, any16());
    send_request(psds_pkg::KIND_SAMPLE, any16(), any16(), 16'sh8000);
    send_request(psds_pkg::KIND_SAMPLE, any16(), any16(), 16'sh7FFF);
    // restart while running, highest target, then run to reached
    send_request(psds_pkg::KIND_START,  16'd1000, 16'sh7FFF, any16());
    send_request(psds_pkg::KIND_TICK,   any16(), any16(), any16());
    send_request(KIND_UNUSED,           any16(), any16(), any16());
    send_request(psds_pkg::KIND_TICK,   any16(), any16(), any16());
    repeat (9) send_request(psds_pkg::KIND_SAMPLE, any16(), any16(), 16'sh7FFF);

    // timeout on the first sample after two ticks
    settle();
    setting = reset_setting;
    setting.timeout_ticks = 32'd1;
    write_settings(setting);
    send_request(psds_pkg::KIND_START,  16'd5, 16'sd100, any16());
    send_request(psds_pkg::KIND_TICK,   any16(), any16(), any16());
    send_request(psds_pkg::KIND_TICK,   any16(), any16(), any16());
    send_request(psds_pkg::KIND_SAMPLE, any16(), any16(), 16'sd100);

    // random phases, each with its own settings and idling
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      setting = reset_setting;
      case (ph)
        0: setting = '0;
        1: setting = '1;
        2: ;
        default: begin
          setting.req_in_win    = 16'($urandom_range(0, 12));
          setting.probe_limit   = any16();
          setting.timeout_ticks = 32'($urandom_range(0, 80));
          setting.coarse_thr    = 16'($urandom_range(0, 40));
          setting.coarse_step   = ($urandom_range(0, 3) == 0) ? any16()
                                                              : 16'($urandom_range(0, 64));
          setting.fine_step     = ($urandom_range(0, 3) == 0) ? any16()
                                                              : 16'($urandom_range(0, 8));
          setting.win_half      = ($urandom_range(0, 3) == 0) ? 15'($urandom())
                                                              : 15'($urandom_range(0, 12));
        end
      endcase
      write_settings(setting);
      in_gap_max  = (ph % 3 == 1) ? 0 : 19;
      out_gap_max = (ph % 4 == 1 || ph % 4 == 2) ? 0 : 19;

      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        code = any16();
        tgt  = any16();
        meas = any16();
        // idle: mostly start a new search; running: mostly samples and ticks
        if (!sb.running)
          kind = (roll < 60) ? psds_pkg::KIND_START : (roll < 80) ? psds_pkg::KIND_SAMPLE :
                 (roll < 95) ? psds_pkg::KIND_TICK : KIND_UNUSED;
        else
          kind = (roll < 4) ? psds_pkg::KIND_START : (roll < 70) ? psds_pkg::KIND_SAMPLE :
                 (roll < 96) ? psds_pkg::KIND_TICK : KIND_UNUSED;
        // start below the probe limit most of the time so the search gets going
        if (kind == psds_pkg::KIND_START && $urandom_range(0, 3) != 0)
          code = 16'($urandom_range(0, sb.regs.probe_limit));
        // samples cluster around the window edges, some wider, a few anywhere
        if (kind == psds_pkg::KIND_SAMPLE) begin
          span = int'(sb.regs.win_half) + 2;
          pick = $urandom_range(0, 9);
          if (pick < 6) off = int'($urandom_range(0, 2 * span)) - span;
          else off = int'($urandom_range(0, 120)) - 60;
          if (pick < 9) meas = 16'(int'(sb.target) + off);
        end
        send_request(kind, code, tgt, meas);
        done++;
      end
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
